### rtl/nctd_pkg.sv
// Shared types, widths and constants for the NMEA coordinate converter.
package nctd_pkg;

    // Field and datapath widths.
    localparam int CHAR_W  = 8;
    localparam int DIG_W   = 4;
    localparam int DEG_W   = 8;
    localparam int MIN_W   = 7;
    localparam int FRAC_W  = 14;
    localparam int SUM_W   = 27;
    localparam int QUOT_W  = 24;
    localparam int RES_W   = 32;
    localparam int RECIP_W = 28;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam int PAD_W   = 3;

    // Default parameter values.
    localparam int MAX_INT_DIGITS_DEF  = 15;
    localparam int FRACTION_DIGITS_DEF = 4;

    // Scale factors.
    localparam logic [RES_W-1:0] DEG_SCALE = 32'd10000000;
    localparam int unsigned      MIN_SCALE = 1000000;

    // Division by six as a multiply by ceil(2^30 / 6) and a shift by 30.
    // Exact for any dividend below 2^27.
    localparam logic [RECIP_W-1:0] RECIP_SIX   = 28'd178956971;
    localparam int                 RECIP_SHIFT = 30;

    // ASCII codes the parser reacts to.
    localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE = 8'h39;
    localparam logic [CHAR_W-1:0] CH_DOT  = 8'h2E;

    // Parser phase.
    typedef enum logic [1:0] {
        PH_INT,
        PH_FRAC,
        PH_DONE
    } t_phase;

    // One finished text, handed from the parser to the arithmetic pipeline.
    typedef struct packed {
        logic [DEG_W-1:0]  deg;
        logic [MIN_W-1:0]  minutes;
        logic [FRAC_W-1:0] frac;
    } t_snap;

    // Power of ten for elaboration-time constants.
    function automatic int unsigned pow10(input int n);
        int unsigned p;
        p = 1;
        for (int i = 0; i < n && i < 9; i++) begin
            p = p * 10;
        end
        return p;
    endfunction

    // Pads a fraction with missing trailing zero digits.
    function automatic logic [FRAC_W-1:0] frac_pad(input logic [FRAC_W-1:0] acc,
                                                   input logic [PAD_W-1:0] n);
        logic [FRAC_W-1:0] r;
        case (n)
            3'd0: r = acc;
            3'd1: r = FRAC_W'(acc * 14'd10);
            3'd2: r = FRAC_W'(acc * 14'd100);
            3'd3: r = FRAC_W'(acc * 14'd1000);
            3'd4: r = FRAC_W'(acc * 14'd10000);
            default: r = acc;
        endcase
        return r;
    endfunction

endpackage

### rtl/nctd_parse.sv
// Character parser: per-item state update and the snapshot register of a finished text.
module nctd_parse
    import nctd_pkg::*;
#(
    parameter int MAX_INT_DIGITS  = MAX_INT_DIGITS_DEF,
    parameter int FRACTION_DIGITS = FRACTION_DIGITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [CHAR_W-1:0] i_char_code,
    input  logic              i_end_of_text,
    output logic              o_stall,
    output logic              o_snap_valid,
    output t_snap             o_snap,
    input  logic              i_snap_stall
);

    localparam int IcntW = $clog2(MAX_INT_DIGITS + 1);
    localparam int FcntW = $clog2(FRACTION_DIGITS + 1);

    t_phase            r_phase, n_phase;
    logic [DEG_W-1:0]  r_deg, n_deg;
    logic [DIG_W-1:0]  r_rd0, n_rd0;
    logic [DIG_W-1:0]  r_rd1, n_rd1;
    logic [1:0]        r_rc, n_rc;
    logic [IcntW-1:0]  r_icnt, n_icnt;
    logic [FRAC_W-1:0] r_facc, n_facc;
    logic [FcntW-1:0]  r_fcnt, n_fcnt;
    logic              r_too_long, n_too_long;

    logic              r_s1_valid;
    t_snap             r_s1;
    t_snap             w_snap;

    logic              w_free;
    logic              w_accept;
    logic              w_digit;
    logic [DIG_W-1:0]  w_d;
    logic [PAD_W-1:0]  w_missing;
    logic [MIN_W-1:0]  w_minutes;

    // The snapshot register can take a new text when empty or draining.
    assign w_free   = !r_s1_valid || !i_snap_stall;
    assign o_stall  = !w_free;
    assign w_accept = i_valid && w_free;

    assign w_digit = (i_char_code >= CH_ZERO) && (i_char_code <= CH_NINE);
    assign w_d     = DIG_W'(i_char_code - CH_ZERO);

    // Next parser state for the accepted character.
    always_comb begin
        n_phase    = r_phase;
        n_deg      = r_deg;
        n_rd0      = r_rd0;
        n_rd1      = r_rd1;
        n_rc       = r_rc;
        n_icnt     = r_icnt;
        n_facc     = r_facc;
        n_fcnt     = r_fcnt;
        n_too_long = r_too_long;
        if (w_accept) begin
            case (r_phase)
                PH_INT: begin
                    if (w_digit) begin
                        if (r_icnt >= IcntW'(MAX_INT_DIGITS)) begin
                            n_too_long = 1'b1;
                            n_phase    = PH_DONE;
                        end else begin
                            n_icnt = r_icnt + IcntW'(1);
                            if (r_rc == 2'd0) begin
                                n_rd0 = w_d;
                                n_rc  = 2'd1;
                            end else if (r_rc == 2'd1) begin
                                n_rd1 = w_d;
                                n_rc  = 2'd2;
                            end else begin
                                // Oldest held digit shifts into the degrees.
                                n_deg = DEG_W'(r_deg * 8'd10 + {4'b0000, r_rd0});
                                n_rd0 = r_rd1;
                                n_rd1 = w_d;
                            end
                        end
                    end else if (i_char_code == CH_DOT) begin
                        n_phase = PH_FRAC;
                    end else begin
                        n_phase = PH_DONE;
                    end
                end
                PH_FRAC: begin
                    if (!w_digit) begin
                        n_phase = PH_DONE;
                    end else if (r_fcnt < FcntW'(FRACTION_DIGITS)) begin
                        n_facc = FRAC_W'(r_facc * 14'd10 + FRAC_W'(w_d));
                        n_fcnt = r_fcnt + FcntW'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Minutes come from the last two integer digits, fewer if fewer were seen.
    always_comb begin
        case (n_rc)
            2'd1:    w_minutes = MIN_W'(n_rd0);
            2'd2:    w_minutes = MIN_W'(MIN_W'(n_rd0) * 7'd10 + MIN_W'(n_rd1));
            default: w_minutes = '0;
        endcase
    end

    // A text with too many integer digits reads as all zeros, which gives a zero result.
    assign w_missing = PAD_W'(FRACTION_DIGITS) - PAD_W'(n_fcnt);
    always_comb begin
        if (n_too_long) begin
            w_snap = '0;
        end else begin
            w_snap.deg     = n_deg;
            w_snap.minutes = w_minutes;
            w_snap.frac    = frac_pad(n_facc, w_missing);
        end
    end

    // Parser state: cleared by reset and after every end item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (w_accept && i_end_of_text)) begin
            r_phase    <= PH_INT;
            r_deg      <= '0;
            r_rd0      <= '0;
            r_rd1      <= '0;
            r_rc       <= '0;
            r_icnt     <= '0;
            r_facc     <= '0;
            r_fcnt     <= '0;
            r_too_long <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_deg      <= n_deg;
            r_rd0      <= n_rd0;
            r_rd1      <= n_rd1;
            r_rc       <= n_rc;
            r_icnt     <= n_icnt;
            r_facc     <= n_facc;
            r_fcnt     <= n_fcnt;
            r_too_long <= n_too_long;
        end
    end

    // Snapshot register for a finished text.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_free) begin
            r_s1_valid <= w_accept && i_end_of_text;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && i_end_of_text) begin
            r_s1 <= w_snap;
        end
    end

    assign o_snap_valid = r_s1_valid;
    assign o_snap       = r_s1;

endmodule

### rtl/nctd_scale.sv
// Arithmetic pipeline: scaling, division by six and the final sum into the result register.
module nctd_scale
    import nctd_pkg::*;
#(
    parameter int FRACTION_DIGITS = FRACTION_DIGITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_snap_valid,
    input  t_snap            i_snap,
    output logic             o_snap_stall,
    output logic             o_valid,
    output logic [RES_W-1:0] o_degrees_e7,
    input  logic             i_stall
);

    localparam int unsigned FracMul = MIN_SCALE / pow10(FRACTION_DIGITS);

    logic              r_s2_valid;
    logic [RES_W-1:0]  r_s2_deg_e7;
    logic [SUM_W-1:0]  r_s2_sum;
    logic              r_s3_valid;
    logic [RES_W-1:0]  r_s3_deg_e7;
    logic [QUOT_W-1:0] r_s3_quot;
    logic              r_out_valid;
    logic [RES_W-1:0]  r_out;

    logic              w_free2, w_free3, w_free_out;
    logic [PROD_W-1:0] w_prod;

    // Each stage loads when it is empty or its content moves on.
    assign w_free_out   = !r_out_valid || !i_stall;
    assign w_free3      = !r_s3_valid || w_free_out;
    assign w_free2      = !r_s2_valid || w_free3;
    assign o_snap_stall = !w_free2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_free2) begin
                r_s2_valid <= i_snap_valid;
            end
            if (w_free3) begin
                r_s3_valid <= r_s2_valid;
            end
            if (w_free_out) begin
                r_out_valid <= r_s3_valid;
            end
        end
    end

    // Stage two: degrees times 10^7 and the minute sum to be divided by six.
    always_ff @(posedge i_clk) begin
        if (w_free2) begin
            r_s2_deg_e7 <= RES_W'(RES_W'(i_snap.deg) * DEG_SCALE);
            r_s2_sum    <= SUM_W'(SUM_W'(i_snap.minutes) * SUM_W'(MIN_SCALE)
                                  + SUM_W'(i_snap.frac) * SUM_W'(FracMul));
        end
    end

    // Stage three: divide by six through the reciprocal.
    assign w_prod = PROD_W'(r_s2_sum) * PROD_W'(RECIP_SIX);

    always_ff @(posedge i_clk) begin
        if (w_free3) begin
            r_s3_deg_e7 <= r_s2_deg_e7;
            r_s3_quot   <= w_prod[RECIP_SHIFT +: QUOT_W];
        end
    end

    // Result register: degrees plus fractional degrees.
    always_ff @(posedge i_clk) begin
        if (w_free_out) begin
            r_out <= r_s3_deg_e7 + RES_W'(r_s3_quot);
        end
    end

    assign o_valid      = r_out_valid;
    assign o_degrees_e7 = r_out;

endmodule

### rtl/nmea_coordinate_to_degrees.sv
// Top level of the NMEA ddmm.mmmm coordinate to 1e-7 degree converter.
// The block takes one ASCII character per item, one item per cycle, and on the item
// marked end_of_text emits the coordinate in units of 1e-7 degree: degrees (the
// integer digits before the last two, kept modulo 256) times 10^7 plus the minutes
// and up to FRACTION_DIGITS fraction digits divided by 60. A text with more than
// MAX_INT_DIGITS integer digits gives 0. After its end item is accepted, a result
// passes through the character parser's snapshot register, which captures the finished
// text at the accepting edge, then the scaling register, the register after the
// reciprocal multiply that divides by six, and the final add into the result
// register. The pipeline holds up to four finished texts, and characters are taken
// every cycle unless all of them are waiting on a stalled output.
module nmea_coordinate_to_degrees
    import nctd_pkg::*;
#(
    parameter int MAX_INT_DIGITS  = MAX_INT_DIGITS_DEF,
    parameter int FRACTION_DIGITS = FRACTION_DIGITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [CHAR_W-1:0] i_char_code,
    input  logic              i_end_of_text,
    output logic              o_stall,
    output logic              o_valid,
    output logic [RES_W-1:0]  o_degrees_e7,
    input  logic              i_stall
);

    logic  w_snap_valid;
    logic  w_snap_stall;
    t_snap w_snap;

    // Character parser.
    nctd_parse #(
        .MAX_INT_DIGITS  (MAX_INT_DIGITS),
        .FRACTION_DIGITS (FRACTION_DIGITS)
    ) u_parse (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_char_code   (i_char_code),
        .i_end_of_text (i_end_of_text),
        .o_stall       (o_stall),
        .o_snap_valid  (w_snap_valid),
        .o_snap        (w_snap),
        .i_snap_stall  (w_snap_stall)
    );

    // Arithmetic pipeline and result register.
    nctd_scale #(
        .FRACTION_DIGITS (FRACTION_DIGITS)
    ) u_scale (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_snap_valid (w_snap_valid),
        .i_snap       (w_snap),
        .o_snap_stall (w_snap_stall),
        .o_valid      (o_valid),
        .o_degrees_e7 (o_degrees_e7),
        .i_stall      (i_stall)
    );

endmodule

### rtl/nctd_checker.sv
// Port-level checker for the coordinate converter, bound to the top level.
module nctd_checker
    import nctd_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic [CHAR_W-1:0] i_char_code,
    input logic              i_end_of_text,
    input logic              o_stall,
    input logic              o_valid,
    input logic [RES_W-1:0]  o_degrees_e7,
    input logic              i_stall
);

    // A stalled result stays and holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_degrees_e7)))
        else $error("stalled result changed or dropped");

    // A stalled input item stays and holds its value.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_stall) |=>
            (i_valid && $stable(i_char_code) && $stable(i_end_of_text)))
        else $error("stalled input item changed or dropped");

    // No result right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // Input back-pressure only when a result is waiting on a stalled output.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without output back-pressure");

    // Largest coordinate: 255 degrees and 99.9999 minutes.
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_degrees_e7 <= 32'd2566666650))
        else $error("result out of range");

endmodule

bind nmea_coordinate_to_degrees nctd_checker u_nctd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .i_char_code   (i_char_code),
    .i_end_of_text (i_end_of_text),
    .o_stall       (o_stall),
    .o_valid       (o_valid),
    .o_degrees_e7  (o_degrees_e7),
    .i_stall       (i_stall)
);
